/* rtl/rxr_pkg.sv */
// ----------------------------------------------------------------------------
// rxr_pkg
// Shared types and constants of the receive ring with delimited capture:
// item structs for both channels, result kinds, register indexes, states.
// ----------------------------------------------------------------------------
package rxr_pkg;

  // Default sizes handed to the top level
  localparam int RING_DEPTH_DEF = 256;
  localparam int MSG_MAX_DEF    = 64;

  // Fixed field widths
  localparam int DATA_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Framing mark and limit bounds
  localparam logic [DATA_W-1:0]  MARK       = 8'h25;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN  = 7'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIVER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_READ   = 2'd1,
    KIND_MSG    = 2'd2
  } kind_t;

  // Input item
  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] rx_byte;
    logic              burst_start;
  } in_item_t;

  // Result item
  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data;
    logic               ok;
    logic               last;
    logic [LEVEL_W-1:0] level;
  } out_item_t;

  // Command codes
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RING_RD,
    ST_MSG_RD,
    ST_MSG_WAIT
  } state_t;

endpackage

/* rtl/rxr_ram.sv */
// ----------------------------------------------------------------------------
// rxr_ram
// Simple dual-port byte memory: one write port, one read port with a
// registered read that holds its data until the next read enable.
// ----------------------------------------------------------------------------
module rxr_ram
  import rxr_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rx_ring_with_delimited_capture.sv */
// ----------------------------------------------------------------------------
// rx_ring_with_delimited_capture
// Receive ring that keeps one slot free, with '%'-delimited message capture
// into a second store and byte-wise delivery of closed messages.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in      | in  | in_valid/in_stall  | in_item  (cmd, rx_byte, burst_start)
//  out     | out | out_valid/out_stall| out_item (kind, data, ok, last, level)
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//
//  A receive's status lands in the output register as the receive is taken.
//  A read with data issues the ring memory read, then loads its result in
//  ST_RING_RD once the output register is free. Each delivered message byte
//  is read from the capture memory in ST_MSG_RD and loaded in ST_MSG_WAIT.
//  Reset is synchronous and clears pointers, counts, framing and registers;
//  both memories need no clearing. An item is taken only in the idle state
//  while the output register is free or being emptied; out_stall holds the
//  pending result and pauses delivery.
// ----------------------------------------------------------------------------
module rx_ring_with_delimited_capture
  import rxr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MSG_MAX    = MSG_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int MIDX_W = $clog2(MSG_MAX);

  // Control and ring state
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   fill_r, fill_nxt;
  logic               capturing_r, capturing_nxt;
  logic               drop_rest_r, drop_rest_nxt;
  logic [MIDX_W-1:0]  msg_len_r, msg_len_nxt;
  logic [MIDX_W-1:0]  msg_idx_r, msg_idx_nxt;
  logic               deliver_en_r;
  logic [LIMIT_W-1:0] msg_limit_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // Memory ports
  logic              ring_we, ring_re;
  logic [PTR_W-1:0]  ring_raddr;
  logic [DATA_W-1:0] ring_rdata;
  logic              msg_we, msg_re;
  logic [MIDX_W-1:0] msg_waddr;
  logic [DATA_W-1:0] msg_wdata, msg_rdata;

  // Decode of the current item
  logic               in_acc, out_free, out_load;
  logic               drop_eff, cap_eff, ring_full, rx_store, rx_deliver;
  logic [PTR_W-1:0]   wr_ptr_inc, rd_ptr_inc;
  logic [LIMIT_W-1:0] lim_c;
  logic [MIDX_W-1:0]  lim_m1, lim_m2;
  logic               at_lim, msg_last;

  rxr_ram #(.DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_ptr_r),
    .wdata (in_item.rx_byte),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  rxr_ram #(.DEPTH(MSG_MAX)) u_msg (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wdata),
    .re    (msg_re),
    .raddr (msg_idx_r),
    .rdata (msg_rdata)
  );

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Pointer wrap, clamped limit and framing decode
  always_comb begin
    wr_ptr_inc = (wr_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_inc = (rd_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (msg_limit_r < LIMIT_MIN) begin
      lim_c = LIMIT_MIN;
    end else if (msg_limit_r > LIMIT_W'(MSG_MAX)) begin
      lim_c = LIMIT_W'(MSG_MAX);
    end else begin
      lim_c = msg_limit_r;
    end
    lim_m1     = MIDX_W'(lim_c - 7'd1);
    lim_m2     = MIDX_W'(lim_c - 7'd2);
    at_lim     = msg_len_r >= lim_m1;
    drop_eff   = drop_rest_r && !in_item.burst_start;
    cap_eff    = capturing_r && !in_item.burst_start;
    ring_full  = wr_ptr_inc == rd_ptr_r;
    rx_store   = !drop_eff && !ring_full;
    rx_deliver = rx_store && cap_eff && (in_item.rx_byte == MARK) && deliver_en_r;
    msg_last   = msg_idx_r == (msg_len_r - 1'b1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == CMD_READ) begin
            if (fill_r != '0) begin
              state_nxt = ST_RING_RD;
            end
          end else if (rx_deliver) begin
            state_nxt = ST_MSG_RD;
          end
        end
      end
      ST_RING_RD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MSG_RD: begin
        state_nxt = ST_MSG_WAIT;
      end
      ST_MSG_WAIT: begin
        if (out_free) begin
          state_nxt = msg_last ? ST_IDLE : ST_MSG_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory controls and result loading
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    capturing_nxt = capturing_r;
    drop_rest_nxt = drop_rest_r;
    msg_len_nxt   = msg_len_r;
    msg_idx_nxt   = msg_idx_r;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    ring_raddr    = rd_ptr_r;
    msg_we        = 1'b0;
    msg_re        = 1'b0;
    msg_waddr     = msg_len_r;
    msg_wdata     = in_item.rx_byte;
    out_load      = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_item.cmd == CMD_READ)) begin
          if (fill_r != '0) begin
            // Issue the ring read and pop now
            ring_re    = 1'b1;
            rd_ptr_nxt = rd_ptr_inc;
            fill_nxt   = fill_r - 1'b1;
          end else begin
            out_load     = 1'b1;
            out_item_nxt = '{kind: KIND_READ, data: '0, ok: 1'b0, last: 1'b1,
                             level: LEVEL_W'(fill_r)};
          end
        end else if (in_acc) begin
          if (in_item.burst_start) begin
            capturing_nxt = 1'b0;
            drop_rest_nxt = 1'b0;
          end
          out_load = 1'b1;
          if (!rx_store) begin
            // Drop this byte and the rest of its burst
            drop_rest_nxt = 1'b1;
            out_item_nxt  = '{kind: KIND_STATUS, data: '0, ok: 1'b0, last: 1'b1,
                              level: LEVEL_W'(fill_r)};
          end else begin
            ring_we    = 1'b1;
            wr_ptr_nxt = wr_ptr_inc;
            fill_nxt   = fill_r + 1'b1;
            // Framing: open, close or capture
            if (in_item.rx_byte == MARK) begin
              msg_we = 1'b1;
              if (!cap_eff) begin
                capturing_nxt = 1'b1;
                msg_waddr     = '0;
                msg_len_nxt   = MIDX_W'(1);
              end else begin
                capturing_nxt = 1'b0;
                msg_waddr     = at_lim ? lim_m2 : msg_len_r;
                msg_len_nxt   = at_lim ? lim_m1 : msg_len_r + 1'b1;
              end
            end else if (cap_eff && !at_lim) begin
              msg_we      = 1'b1;
              msg_len_nxt = msg_len_r + 1'b1;
            end
            msg_idx_nxt  = '0;
            out_item_nxt = '{kind: KIND_STATUS, data: '0, ok: 1'b1,
                             last: !rx_deliver, level: LEVEL_W'(fill_nxt)};
          end
        end
      end
      ST_RING_RD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_item_nxt = '{kind: KIND_READ, data: ring_rdata, ok: 1'b1, last: 1'b1,
                           level: LEVEL_W'(fill_r)};
        end
      end
      ST_MSG_RD: begin
        msg_re = 1'b1;
      end
      ST_MSG_WAIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          msg_idx_nxt  = msg_idx_r + 1'b1;
          out_item_nxt = '{kind: KIND_MSG, data: msg_rdata, ok: 1'b0, last: msg_last,
                           level: LEVEL_W'(fill_r)};
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      capturing_r <= 1'b0;
      drop_rest_r <= 1'b0;
      msg_len_r   <= '0;
      msg_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      capturing_r <= capturing_nxt;
      drop_rest_r <= drop_rest_nxt;
      msg_len_r   <= msg_len_nxt;
      msg_idx_r   <= msg_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_en_r <= 1'b0;
      msg_limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIVER: deliver_en_r <= cfg_wdata[0];
        REG_LIMIT:   msg_limit_r  <= cfg_wdata;
        default:     deliver_en_r <= deliver_en_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Fill count agrees with the pointer distance
  a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r >= rd_ptr_r) ? (int'(fill_r) == int'(wr_ptr_r) - int'(rd_ptr_r))
                           : (int'(fill_r) == int'(wr_ptr_r) + RING_DEPTH - int'(rd_ptr_r)))
    else $error("ring fill count out of step with pointers");

  // A stored byte raises the level by one
  a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_item.cmd == CMD_RX) && rx_store) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("stored byte did not raise the fill count");

  // Never take an item over a held result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(out_valid_r && out_stall))
    else $error("item taken while a result is held");

  // The final message byte returns the block to idle
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSG_WAIT && out_load && msg_last) |=> (state_r == ST_IDLE))
    else $error("delivery did not end on the last message byte");
`endif

endmodule

/* verif/rx_ring_with_delimited_capture_test.sv */
// ----------------------------------------------------------------------------
// rx_ring_with_delimited_capture_test
// Self-checking bench for the receive ring with '%'-delimited capture. A
// queue-fed driver offers receive and read items, a clocked monitor keeps a
// copy of the ring and the framing state, and every result is compared
// field by field, in order. Phases change the delivery and limit registers
// while the block is idle; one phase floods the ring past full under a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module rx_ring_with_delimited_capture_test;
  import rxr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 17;
  localparam int MAX_REPORTS = 30;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Items waiting to be offered, and results owed by the block
  in_item_t  byte_backlog[$];
  out_item_t owed_results[$];

  // Mirror of the block state and registers
  logic [DATA_W-1:0]  ring_mem [RING_DEPTH_DEF];
  logic [DATA_W-1:0]  msg_mem [MSG_MAX_DEF];
  int                 wr_ptr;
  int                 rd_ptr;
  int                 ring_fill;
  int                 msg_len;
  bit                 capturing;
  bit                 drop_rest;
  bit                 deliver_on;
  logic [LIMIT_W-1:0] limit_reg;

  // Run control shared between the processes
  bit in_took;
  bit steady;
  int hold_asked;
  int hold_given;
  int hold_left;
  int cycle_count;
  int errors;
  int n_stored;
  int n_dropped;
  int n_reads;
  int n_msg_bytes;
  int n_checked;

  rx_ring_with_delimited_capture u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, owed_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Work out the results of one accepted item and advance the mirror
  task automatic ring_frame_step(input in_item_t it);
    out_item_t r;
    int        lim;
    int        nxt;
    int        i;
    bit        closed;
    closed = 1'b0;
    r      = '0;
    r.last = 1'b1;
    if (it.cmd == CMD_READ) begin
      r.kind = KIND_READ;
      n_reads++;
      if (ring_fill > 0) begin
        r.data    = ring_mem[rd_ptr];
        r.ok      = 1'b1;
        rd_ptr    = (rd_ptr + 1) % RING_DEPTH_DEF;
        ring_fill = ring_fill - 1;
      end
      r.level = ring_fill[LEVEL_W-1:0];
      owed_results.push_back(r);
    end else begin
      r.kind = KIND_STATUS;
      if (it.burst_start) begin
        capturing = 1'b0;
        drop_rest = 1'b0;
      end
      nxt = (wr_ptr + 1) % RING_DEPTH_DEF;
      if (drop_rest || nxt == rd_ptr) begin
        // Ring full or burst already dropping: drop this byte and the rest of the burst
        drop_rest = 1'b1;
        n_dropped++;
      end else begin
        ring_mem[wr_ptr] = it.rx_byte;
        wr_ptr    = nxt;
        ring_fill = ring_fill + 1;
        r.ok      = 1'b1;
        n_stored++;
        lim = (limit_reg < LIMIT_MIN) ? LIMIT_MIN :
              (limit_reg > MSG_MAX_DEF) ? MSG_MAX_DEF : limit_reg;
        if (it.rx_byte == MARK && !capturing) begin
          capturing  = 1'b1;
          msg_mem[0] = MARK;
          msg_len    = 1;
        end else if (it.rx_byte == MARK) begin
          // Close; at the limit the mark overwrites the final byte
          if (msg_len >= lim - 1) begin
            msg_len            = lim - 1;
            msg_mem[lim - 2]   = MARK;
          end else begin
            msg_mem[msg_len] = MARK;
            msg_len++;
          end
          capturing = 1'b0;
          closed    = deliver_on;
        end else if (capturing && msg_len < lim - 1) begin
          msg_mem[msg_len] = it.rx_byte;
          msg_len++;
        end
      end
      r.level = ring_fill[LEVEL_W-1:0];
      r.last  = !closed;
      owed_results.push_back(r);
      if (closed) begin
        for (i = 0; i < msg_len; i++) begin
          r.kind = KIND_MSG;
          r.data = msg_mem[i];
          r.ok   = 1'b0;
          r.last = (i == msg_len - 1);
          owed_results.push_back(r);
          n_msg_bytes++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Monitor: track registers, accepted items and accepted results
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wr_ptr     = 0;
      rd_ptr     = 0;
      ring_fill  = 0;
      msg_len    = 0;
      capturing  = 1'b0;
      drop_rest  = 1'b0;
      deliver_on = 1'b0;
      limit_reg  = LIMIT_RST;
      in_took    = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DELIVER: deliver_on = cfg_wdata[0];
          REG_LIMIT:   limit_reg  = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      in_took = in_valid && !in_stall;
      if (in_took)
        ring_frame_step(in_item);
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        end else begin
          want = owed_results.pop_front();
          n_checked++;
          check_field("kind", 8'(want.kind), 8'(out_item.kind));
          check_field("data", want.data, out_item.data);
          check_field("ok", 8'(want.ok), 8'(out_item.ok));
          check_field("last", 8'(want.last), 8'(out_item.last));
          check_field("level", want.level, out_item.level);
        end
      end
    end
  end

  // Driver: hold a stalled item, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (byte_backlog.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
      in_item  <= byte_backlog.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic push_rx(input logic [DATA_W-1:0] b, input logic bs);
    in_item_t it;
    it.cmd         = CMD_RX;
    it.rx_byte     = b;
    it.burst_start = bs;
    byte_backlog.push_back(it);
  endtask

  // Reads carry random filler in the ignored fields
  task automatic push_read();
    in_item_t it;
    it.cmd         = CMD_READ;
    it.rx_byte     = DATA_W'($urandom_range(255));
    it.burst_start = 1'($urandom_range(1));
    byte_backlog.push_back(it);
  endtask

  // Queue about n items: mostly framed messages with random bodies, some
  // reads, some fully random items, and now and then an unclosed frame
  task automatic queue_traffic(input int n, input int read_pct, input int noise_pct);
    int               target;
    int               roll;
    int               body;
    int               k;
    logic [DATA_W-1:0] b;
    in_item_t          it;
    target = byte_backlog.size() + n;
    while (byte_backlog.size() < target) begin
      roll = $urandom_range(99);
      if (roll < read_pct) begin
        push_read();
      end else if (roll < read_pct + noise_pct) begin
        it.cmd         = 1'($urandom_range(1));
        it.rx_byte     = DATA_W'($urandom_range(255));
        it.burst_start = 1'($urandom_range(1));
        byte_backlog.push_back(it);
      end else begin
        body = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
        push_rx(MARK, 1'($urandom_range(1)));
        for (k = 0; k < body; k++) begin
          b = DATA_W'($urandom_range(255));
          if (b == MARK)
            b = 8'h24;
          push_rx(b, 1'b0);
        end
        if ($urandom_range(7) != 0)
          push_rx(MARK, 1'b0);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until everything offered is taken and every result is in
  task automatic settle();
    while (byte_backlog.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: read on empty ring, byte extremes, message dropped
    // silently with delivery off
    push_read();
    push_rx(8'h00, 1'b1);
    push_rx(8'hFF, 1'b0);
    push_rx(MARK, 1'b0);
    push_rx(8'h5A, 1'b0);
    push_rx(MARK, 1'b0);
    push_read();
    push_read();
    settle();

    // Limit below range clamps to three: closing mark replaces final byte
    write_reg(REG_DELIVER, 7'd1);
    write_reg(REG_LIMIT, 7'd0);
    push_rx(MARK, 1'b1);
    push_rx(8'h41, 1'b0);
    push_rx(8'h42, 1'b0);
    push_rx(MARK, 1'b0);
    settle();

    // Limit above range; zero byte inside a message; burst start abandons
    // an open capture
    write_reg(REG_LIMIT, 7'd127);
    push_rx(MARK, 1'b1);
    push_rx(8'h00, 1'b0);
    push_rx(8'hA5, 1'b0);
    push_rx(MARK, 1'b0);
    push_rx(MARK, 1'b0);
    push_rx(8'h71, 1'b0);
    push_rx(8'h72, 1'b1);
    push_rx(MARK, 1'b0);
    push_rx(MARK, 1'b0);
    push_read();
    push_read();
    settle();

    // Short limit, no idling on either side
    write_reg(REG_LIMIT, 7'd5);
    steady = 1'b1;
    queue_traffic(50, 35, 10);
    settle();
    steady = 1'b0;

    // Empty the ring, then flood it past full under a long hold-off
    write_reg(REG_LIMIT, 7'd64);
    repeat (ring_fill) push_read();
    settle();
    hold_asked++;
    queue_traffic(262, 0, 0);
    settle();

    // Reads free space while the burst stays dropped until a burst start
    queue_traffic(50, 50, 10);
    settle();

    // Delivery off at the lowest legal limit, heavy noise
    write_reg(REG_DELIVER, 7'd0);
    write_reg(REG_LIMIT, 7'd3);
    queue_traffic(25, 30, 40);
    settle();
    repeat (20) @(posedge clk);

    $display("Covered %0d stored and %0d dropped receives, %0d reads, %0d message bytes.",
             n_stored, n_dropped, n_reads, n_msg_bytes);
    $display("Compared %0d results over %0d cycles, %0d mismatches.",
             n_checked, cycle_count, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rxr_pkg.sv
rtl/rxr_ram.sv
rtl/rx_ring_with_delimited_capture.sv
verif/rx_ring_with_delimited_capture_test.sv
